// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the keypad scanner modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KPS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KPS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/kps_pkg.sv -----
// Package for the matrix keypad scanner: sizes, register indexes and the
// command/status bundles between controller and datapath. No dependencies.
package kps_pkg;

    localparam int MAX_ROWS      = 8;
    localparam int MAX_COLUMNS   = 8;
    localparam int TIMER_BITS    = 16;
    localparam int KEY_SLOTS     = MAX_ROWS * MAX_COLUMNS;
    localparam int KEY_ADDR_BITS = 6;
    localparam int ROW_PIN_BITS  = 8;
    localparam int COL_PIN_BITS  = 8;
    localparam int ROW_IDX_BITS  = 3;
    localparam int COUNT_BITS    = 4;
    localparam int DELAY_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;

    typedef logic [TIMER_BITS-1:0]    t_timer;
    typedef logic [KEY_ADDR_BITS-1:0] t_key;
    typedef logic [COUNT_BITS-1:0]    t_count;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_COUNT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_TICKS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLL_TICKS   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_HIGH  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRIVE_IDLE   = 3'd5;

    typedef struct packed {
        logic accept;     // take the tick beat
        logic row_adv;    // retire the current row
        logic emit_last;  // load the closing result beat
    } t_ctrl_cmd;

    typedef struct packed {
        logic sample;     // this tick fires on an in-range column
        logic hold;       // a pending event cannot be pushed out yet
        logic last_row;   // current row is the last one in use
        logic out_free;   // output register can take a beat
    } t_dp_stat;

endpackage

// ----- hdl/kps_ctrl.sv -----
// Scan controller: sequences tick accept, row walk and closing result.
// Depends on kps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kps_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  kps_pkg::t_dp_stat    i_stat,
    output kps_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROW  = 3'b010,
        S_LAST = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.sample ? S_ROW : S_LAST;
                end
            end
            S_ROW: begin
                if (!i_stat.hold) begin
                    o_cmd.row_adv = 1'b1;
                    if (i_stat.last_row) begin
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    `KPS_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, o_cmd.accept, r_state != S_IDLE, "accept did not start work")
    `KPS_ASSERT_NXT(a_last_row_closes, i_clk, i_rst_n, r_state == S_ROW && i_stat.last_row && !i_stat.hold, r_state == S_LAST, "last row did not close the tick")
    `KPS_ASSERT_NXT(a_close_to_idle, i_clk, i_rst_n, r_state == S_LAST && i_stat.out_free, r_state == S_IDLE, "closing beat did not return to idle")

endmodule

// ----- hdl/kps_datapath.sv -----
// Scanner datapath: config registers, countdown, column pointer, key bitmap
// memory with valid bits, pending event and output register. Uses kps_pkg.
`include "assert_macros.svh"

module kps_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kps_pkg::t_ctrl_cmd                   i_cmd,
    output kps_pkg::t_dp_stat                    o_stat,
    input  logic [kps_pkg::ROW_PIN_BITS-1:0]     i_row_pins,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kps_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [kps_pkg::DELAY_BITS-1:0]       i_cfg_data,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [kps_pkg::COL_PIN_BITS-1:0]     o_column_level,
    output logic [kps_pkg::COL_PIN_BITS-1:0]     o_column_enable,
    output logic                                 o_event_valid,
    output logic [kps_pkg::KEY_ADDR_BITS-1:0]    o_key_number,
    output logic                                 o_key_down,
    output logic                                 o_scan_complete,
    output logic                                 o_last_of_run
);

    // configuration
    kps_pkg::t_count                  r_cfg_rows;
    kps_pkg::t_count                  r_cfg_cols;
    logic [kps_pkg::DELAY_BITS-1:0]   r_cfg_settle;
    logic [kps_pkg::DELAY_BITS-1:0]   r_cfg_poll;
    logic                             r_cfg_active_high;
    logic                             r_cfg_drive_idle;

    // scan state
    kps_pkg::t_count                  r_active_column;
    kps_pkg::t_timer                  r_countdown;
    logic                             r_done;
    logic [kps_pkg::ROW_PIN_BITS-1:0] r_pins;
    logic [kps_pkg::ROW_IDX_BITS-1:0] r_row;
    kps_pkg::t_key                    r_key;

    // key bitmap
    logic                             r_key_mem [0:kps_pkg::KEY_SLOTS-1];
    logic [kps_pkg::KEY_SLOTS-1:0]    r_key_vld;
    logic                             r_rd_bit;
    logic                             r_rd_vld;

    // pending event and output register
    logic                             r_pend_valid;
    kps_pkg::t_key                    r_pend_key;
    logic                             r_pend_down;
    logic                             r_out_valid;

    kps_pkg::t_count                  rows_eff;
    kps_pkg::t_count                  cols_eff;
    logic                             timer_zero;
    logic                             col_in_range;
    logic [2*kps_pkg::COUNT_BITS-1:0] base_prod;
    kps_pkg::t_key                    key_base;
    kps_pkg::t_count                  n_column;
    logic                             n_done;
    kps_pkg::t_key                    rd_addr;
    logic                             pressed;
    logic                             change;
    logic                             out_free;
    logic                             out_load_row;
    logic [kps_pkg::COL_PIN_BITS-1:0] pin_level;
    logic [kps_pkg::COL_PIN_BITS-1:0] pin_enable;

    assign o_cfg_ready = 1'b1;

    assign rows_eff = (r_cfg_rows > kps_pkg::COUNT_BITS'(kps_pkg::MAX_ROWS))
                    ? kps_pkg::COUNT_BITS'(kps_pkg::MAX_ROWS) : r_cfg_rows;
    assign cols_eff = (r_cfg_cols > kps_pkg::COUNT_BITS'(kps_pkg::MAX_COLUMNS))
                    ? kps_pkg::COUNT_BITS'(kps_pkg::MAX_COLUMNS) : r_cfg_cols;

    assign timer_zero   = (r_countdown == '0);
    assign col_in_range = (r_active_column < cols_eff);
    assign base_prod    = r_active_column * rows_eff;
    assign key_base     = base_prod[kps_pkg::KEY_ADDR_BITS-1:0];
    assign n_column     = col_in_range ? r_active_column + 1'b1 : '0;
    assign n_done       = (n_column >= cols_eff);

    assign pressed  = (r_pins[r_row] == r_cfg_active_high);
    assign change   = ((r_rd_vld & r_rd_bit) != pressed);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_stat          = '0;
        o_stat.sample   = timer_zero && col_in_range && (rows_eff != '0);
        o_stat.hold     = change && r_pend_valid && !out_free;
        o_stat.last_row = ({1'b0, r_row} == rows_eff - 1'b1);
        o_stat.out_free = out_free;
    end

    // read the column's first key on accept, re-read the current key while holding, prefetch the next on advance
    always_comb begin
        if (i_cmd.row_adv) begin
            rd_addr = r_key + 1'b1;
        end else if (i_cmd.accept) begin
            rd_addr = key_base;
        end else begin
            rd_addr = r_key;
        end
    end

    assign out_load_row = i_cmd.row_adv && change && r_pend_valid;

    // column pins follow the pointer as left by the accepted tick
    always_comb begin
        pin_level  = '0;
        pin_enable = '0;
        for (int j = 0; j < kps_pkg::COL_PIN_BITS; j++) begin
            if (kps_pkg::COUNT_BITS'(j) < cols_eff) begin
                if (kps_pkg::COUNT_BITS'(j) == r_active_column) begin
                    pin_level[j]  = r_cfg_active_high;
                    pin_enable[j] = 1'b1;
                end else if (r_cfg_drive_idle) begin
                    pin_level[j]  = ~r_cfg_active_high;
                    pin_enable[j] = 1'b1;
                end else begin
                    pin_level[j]  = r_cfg_active_high;
                    pin_enable[j] = 1'b0;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows        <= kps_pkg::COUNT_BITS'(8);
            r_cfg_cols        <= kps_pkg::COUNT_BITS'(8);
            r_cfg_settle      <= '0;
            r_cfg_poll        <= kps_pkg::DELAY_BITS'(10);
            r_cfg_active_high <= 1'b0;
            r_cfg_drive_idle  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kps_pkg::CFG_ROW_COUNT: begin
                    r_cfg_rows <= i_cfg_data[kps_pkg::COUNT_BITS-1:0];
                end
                kps_pkg::CFG_COLUMN_COUNT: begin
                    r_cfg_cols <= i_cfg_data[kps_pkg::COUNT_BITS-1:0];
                end
                kps_pkg::CFG_SETTLE_TICKS: begin
                    r_cfg_settle <= i_cfg_data;
                end
                kps_pkg::CFG_POLL_TICKS: begin
                    r_cfg_poll <= i_cfg_data;
                end
                kps_pkg::CFG_ACTIVE_HIGH: begin
                    r_cfg_active_high <= i_cfg_data[0];
                end
                kps_pkg::CFG_DRIVE_IDLE: begin
                    r_cfg_drive_idle <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // countdown, column pointer, pending event, valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_column <= kps_pkg::COUNT_BITS'(8);
            r_countdown     <= '0;
            r_pend_valid    <= 1'b0;
            r_key_vld       <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_pend_valid <= 1'b0;
                if (!timer_zero) begin
                    r_countdown <= r_countdown - 1'b1;
                end else begin
                    r_active_column <= n_column;
                    r_countdown     <= n_done ? kps_pkg::t_timer'(r_cfg_poll)
                                              : kps_pkg::t_timer'(r_cfg_settle);
                end
            end else if (i_cmd.row_adv && change) begin
                r_pend_valid     <= 1'b1;
                r_key_vld[r_key] <= 1'b1;
            end else if (i_cmd.emit_last) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // per-tick payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pins <= i_row_pins;
            r_row  <= '0;
            r_key  <= key_base;
            r_done <= timer_zero && n_done;
        end else if (i_cmd.row_adv) begin
            r_row <= r_row + 1'b1;
            r_key <= r_key + 1'b1;
            if (change) begin
                r_pend_key  <= r_key;
                r_pend_down <= pressed;
            end
        end
    end

    // bitmap memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_adv && change) begin
            r_key_mem[r_key] <= pressed;
        end
        r_rd_bit <= r_key_mem[rd_addr];
        r_rd_vld <= r_key_vld[rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load_row || i_cmd.emit_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load_row || i_cmd.emit_last) begin
            o_column_level  <= pin_level;
            o_column_enable <= pin_enable;
            o_event_valid   <= r_pend_valid;
            o_key_number    <= r_pend_valid ? r_pend_key : '0;
            o_key_down      <= r_pend_valid & r_pend_down;
            o_scan_complete <= r_done;
            o_last_of_run   <= i_cmd.emit_last;
        end
    end

    assign o_valid = r_out_valid;

    `KPS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, out_load_row || i_cmd.emit_last, out_free, "result beat overwrote a waiting beat")
    `KPS_ASSERT_NXT(a_countdown_dec, i_clk, i_rst_n, i_cmd.accept && !timer_zero, r_countdown == $past(r_countdown) - 1'b1, "countdown did not decrement")
    `KPS_ASSERT_NXT(a_pend_cleared, i_clk, i_rst_n, i_cmd.accept, !r_pend_valid, "pending event survived a new tick")

endmodule

// ----- hdl/matrix_keypad_scanner_unit.sv -----
// Top level of the matrix keypad scanner: controller plus datapath.
// Depends on kps_pkg, kps_ctrl and kps_datapath.
//
//   channel  direction  handshake                payload
//   tick     in         i_valid / o_stall        i_row_pins
//   result   out        o_valid / i_stall        column pins, event, flags
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A tick that does not sample runs accept, then its single beat. A sampling
// tick runs accept, a step per row through the bitmap memory, then the
// closing beat; holds and output stalls lengthen it. Reset loads the default
// config, zeroes the countdown, parks the column pointer out of range and
// clears the per-key valid bits; no clearing pass runs. A result beat waits
// in the output register while the next tick is accepted and started.

module matrix_keypad_scanner_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [kps_pkg::ROW_PIN_BITS-1:0]     i_row_pins,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [kps_pkg::COL_PIN_BITS-1:0]     o_column_level,
    output logic [kps_pkg::COL_PIN_BITS-1:0]     o_column_enable,
    output logic                                 o_event_valid,
    output logic [kps_pkg::KEY_ADDR_BITS-1:0]    o_key_number,
    output logic                                 o_key_down,
    output logic                                 o_scan_complete,
    output logic                                 o_last_of_run,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kps_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [kps_pkg::DELAY_BITS-1:0]       i_cfg_data
);

    kps_pkg::t_ctrl_cmd cmd;
    kps_pkg::t_dp_stat  stat;

    kps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    kps_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_row_pins      (i_row_pins),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_column_level  (o_column_level),
        .o_column_enable (o_column_enable),
        .o_event_valid   (o_event_valid),
        .o_key_number    (o_key_number),
        .o_key_down      (o_key_down),
        .o_scan_complete (o_scan_complete),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
